/* sv/usb_config_descriptor_walker_core_macros.svh */
// ----------------------------------------------------------------------------
// USB configuration descriptor walker: assertion macros
// Shared concurrent assertion forms used by the walker RTL.
// ----------------------------------------------------------------------------
`ifndef USB_CONFIG_DESCRIPTOR_WALKER_CORE_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_WALKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UCDW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucdw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UCDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucdw assertion failed");

`endif

/* sv/ucdw_pkg.sv */
// ----------------------------------------------------------------------------
// USB configuration descriptor walker package
// Types, codes and constants shared by the walker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ucdw_pkg;

    localparam int MAX_ENDPOINTS = 32;
    localparam int COUNT_W       = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] ANY_INTERFACE  = 8'hff;

    // Byte offsets inside a descriptor.
    localparam logic [7:0] POS_LENGTH   = 8'd0;
    localparam logic [7:0] POS_TYPE     = 8'd1;
    localparam logic [7:0] POS_IF_NUM   = 8'd2;
    localparam logic [7:0] POS_IF_ALT   = 8'd3;
    localparam logic [7:0] POS_IF_NEP   = 8'd4;
    localparam logic [7:0] POS_IF_LAST  = 8'd8;
    localparam logic [7:0] POS_EP_ADDR  = 8'd2;
    localparam logic [7:0] POS_EP_ATTR  = 8'd3;
    localparam logic [7:0] POS_EP_MPS_L = 8'd4;
    localparam logic [7:0] POS_EP_MPS_H = 8'd5;
    localparam logic [7:0] POS_EP_INTV  = 8'd6;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_COLLECT = 2'd1,
        PH_FOUND   = 2'd2,
        PH_LOST    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENDPOINT  = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t          kind;
        logic [7:0]         endpoint_address;
        logic [1:0]         transfer_type;
        logic [15:0]        max_packet_size;
        logic [7:0]         poll_interval;
        logic [COUNT_W-1:0] endpoint_count;
        logic               last_of_run;
    } rec_t;

    // Results of one parsed byte, in output order.
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    typedef struct packed {
        logic [1:0] free;
    } queue_status_t;

endpackage

`default_nettype wire

/* sv/ucdw_if.sv */
// ----------------------------------------------------------------------------
// USB configuration descriptor walker channel interfaces
// Valid/ready channels for descriptor bytes and for result records.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucdw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_config;

    modport source (output valid, data_byte, first_byte, end_of_config, input ready);
    modport sink   (input valid, data_byte, first_byte, end_of_config, output ready);
endinterface

interface ucdw_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  endpoint_address;
    logic [1:0]  transfer_type;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic [5:0]  endpoint_count;
    logic        last_of_run;

    modport source (output valid, record_kind, endpoint_address, transfer_type,
                    max_packet_size, poll_interval, endpoint_count, last_of_run,
                    input ready);
    modport sink   (input valid, record_kind, endpoint_address, transfer_type,
                    max_packet_size, poll_interval, endpoint_count, last_of_run,
                    output ready);
endinterface

`default_nettype wire

/* sv/ucdw_parser.sv */
// ----------------------------------------------------------------------------
// USB configuration descriptor walker parser
// Input register, descriptor walk state and per-byte result generation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usb_config_descriptor_walker_core_macros.svh"

module ucdw_parser (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [7:0]             cfg_write_data,
    ucdw_byte_if.sink                   byte_in,
    input  wire ucdw_pkg::queue_status_t q_status,
    output ucdw_pkg::push_t             push
);
    import ucdw_pkg::*;

    // Input register.
    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_first_reg;
    logic       item_last_reg;

    logic [7:0] target_reg;

    // Walk state.
    phase_t             phase_reg, phase_next;
    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         if_num_reg, if_num_next;
    logic [7:0]         if_alt_reg, if_alt_next;
    logic [7:0]         exp_ep_reg, exp_ep_next;
    logic [7:0]         ep_addr_reg, ep_addr_next;
    logic [1:0]         ep_attr_reg, ep_attr_next;
    logic [15:0]        ep_mps_reg, ep_mps_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // State as seen by the current byte (after an optional restart).
    phase_t             ph_cur;
    logic [7:0]         pos_cur, type_cur, if_num_cur, if_alt_cur, exp_ep_cur;
    logic [7:0]         ep_addr_cur;
    logic [1:0]         ep_attr_cur;
    logic [15:0]        ep_mps_cur;
    logic [COUNT_W-1:0] count_cur, count_inc;

    logic       emit_ep;
    logic       fire;
    logic [1:0] need;
    rec_t       ep_rec, done_rec;

    assign need = {1'b0, emit_ep} + {1'b0, item_last_reg};
    assign fire = item_valid_reg && (need <= q_status.free);
    assign byte_in.ready = !item_valid_reg || fire;
    assign count_inc = count_cur + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            item_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            item_byte_reg  <= byte_in.data_byte;
            item_first_reg <= byte_in.first_byte;
            item_last_reg  <= byte_in.end_of_config;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= ANY_INTERFACE;
        end
        else if (cfg_write_en)
        begin
            target_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            pos_reg     <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            if_num_reg  <= '0;
            if_alt_reg  <= '0;
            exp_ep_reg  <= '0;
            ep_addr_reg <= '0;
            ep_attr_reg <= '0;
            ep_mps_reg  <= '0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            if_num_reg  <= if_num_next;
            if_alt_reg  <= if_alt_next;
            exp_ep_reg  <= exp_ep_next;
            ep_addr_reg <= ep_addr_next;
            ep_attr_reg <= ep_attr_next;
            ep_mps_reg  <= ep_mps_next;
            count_reg   <= count_next;
        end
    end

    // Restart view: a first byte sees the cleared parser.
    always_comb
    begin
        if (item_first_reg)
        begin
            ph_cur      = PH_SEARCH;
            pos_cur     = '0;
            type_cur    = '0;
            if_num_cur  = '0;
            if_alt_cur  = '0;
            exp_ep_cur  = '0;
            ep_addr_cur = '0;
            ep_attr_cur = '0;
            ep_mps_cur  = '0;
            count_cur   = '0;
        end
        else
        begin
            ph_cur      = phase_reg;
            pos_cur     = pos_reg;
            type_cur    = type_reg;
            if_num_cur  = if_num_reg;
            if_alt_cur  = if_alt_reg;
            exp_ep_cur  = exp_ep_reg;
            ep_addr_cur = ep_addr_reg;
            ep_attr_cur = ep_attr_reg;
            ep_mps_cur  = ep_mps_reg;
            count_cur   = count_reg;
        end
    end

    always_comb
    begin
        phase_next   = ph_cur;
        pos_next     = pos_cur;
        len_next     = item_first_reg ? 8'd0 : len_reg;
        type_next    = type_cur;
        if_num_next  = if_num_cur;
        if_alt_next  = if_alt_cur;
        exp_ep_next  = exp_ep_cur;
        ep_addr_next = ep_addr_cur;
        ep_attr_next = ep_attr_cur;
        ep_mps_next  = ep_mps_cur;
        count_next   = count_cur;
        emit_ep      = 1'b0;

        if (ph_cur == PH_SEARCH || ph_cur == PH_COLLECT)
        begin
            if (pos_cur == POS_LENGTH)
            begin
                len_next  = item_byte_reg;
                type_next = '0;
                if (item_byte_reg == 8'd0)
                begin
                    phase_next = (ph_cur == PH_COLLECT) ? PH_FOUND : PH_LOST;
                end
            end
            else if (pos_cur == POS_TYPE)
            begin
                type_next = item_byte_reg;
                if (ph_cur == PH_COLLECT && item_byte_reg == TYPE_INTERFACE)
                begin
                    phase_next = PH_FOUND;
                end
            end
            else if (ph_cur == PH_SEARCH && type_cur == TYPE_INTERFACE)
            begin
                if (pos_cur == POS_IF_NUM)
                begin
                    if_num_next = item_byte_reg;
                end
                else if (pos_cur == POS_IF_ALT)
                begin
                    if_alt_next = item_byte_reg;
                end
                else if (pos_cur == POS_IF_NEP)
                begin
                    exp_ep_next = item_byte_reg;
                end
                else if (pos_cur == POS_IF_LAST && if_alt_cur == 8'd0 &&
                         (target_reg == ANY_INTERFACE || if_num_cur == target_reg))
                begin
                    count_next = '0;
                    phase_next = (exp_ep_cur == 8'd0) ? PH_FOUND : PH_COLLECT;
                end
            end
            else if (ph_cur == PH_COLLECT && type_cur == TYPE_ENDPOINT)
            begin
                if (pos_cur == POS_EP_ADDR)
                begin
                    ep_addr_next = item_byte_reg;
                end
                else if (pos_cur == POS_EP_ATTR)
                begin
                    ep_attr_next = item_byte_reg[1:0];
                end
                else if (pos_cur == POS_EP_MPS_L)
                begin
                    ep_mps_next = {ep_mps_cur[15:8], item_byte_reg};
                end
                else if (pos_cur == POS_EP_MPS_H)
                begin
                    ep_mps_next = {item_byte_reg, ep_mps_cur[7:0]};
                end
                else if (pos_cur == POS_EP_INTV)
                begin
                    count_next = count_inc;
                    emit_ep    = 1'b1;
                    if ({2'b00, count_inc} >= exp_ep_cur ||
                        count_inc >= COUNT_W'(MAX_ENDPOINTS))
                    begin
                        phase_next = PH_FOUND;
                    end
                end
            end

            if (phase_next == PH_SEARCH || phase_next == PH_COLLECT)
            begin
                if ({1'b0, pos_cur} + 9'd1 >= {1'b0, len_next})
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_cur + 8'd1;
                end
            end
        end

        ep_rec.kind             = KIND_ENDPOINT;
        ep_rec.endpoint_address = ep_addr_cur;
        ep_rec.transfer_type    = ep_attr_cur;
        ep_rec.max_packet_size  = ep_mps_cur;
        ep_rec.poll_interval    = item_byte_reg;
        ep_rec.endpoint_count   = count_inc;
        ep_rec.last_of_run      = !item_last_reg;

        done_rec.kind = (phase_next == PH_COLLECT || phase_next == PH_FOUND) ?
                        KIND_FOUND : KIND_NOT_FOUND;
        done_rec.endpoint_address = '0;
        done_rec.transfer_type    = '0;
        done_rec.max_packet_size  = '0;
        done_rec.poll_interval    = '0;
        done_rec.endpoint_count   = count_next;
        done_rec.last_of_run      = 1'b1;

        // The final byte of a set leaves the parser cleared for the next set.
        if (item_last_reg)
        begin
            phase_next   = PH_SEARCH;
            pos_next     = '0;
            len_next     = '0;
            type_next    = '0;
            if_num_next  = '0;
            if_alt_next  = '0;
            exp_ep_next  = '0;
            ep_addr_next = '0;
            ep_attr_next = '0;
            ep_mps_next  = '0;
            count_next   = '0;
        end

        push.cnt  = fire ? need : 2'd0;
        push.rec0 = emit_ep ? ep_rec : done_rec;
        push.rec1 = done_rec;
    end

    // A parsed byte never pushes more results than the queue can take.
    `UCDW_ASSERT_SAME(a_push_fits, clk, rst_n, push.cnt != 2'd0, push.cnt <= q_status.free)
    // The final byte of a set always leaves the walk at the start of a search.
    `UCDW_ASSERT_NEXT(a_clear_after_last, clk, rst_n, fire && item_last_reg,
                      phase_reg == PH_SEARCH && pos_reg == 8'd0 && count_reg == '0)
    // The collected count never passes the endpoint limit.
    `UCDW_ASSERT_SAME(a_count_limit, clk, rst_n, 1'b1,
                      count_reg <= COUNT_W'(MAX_ENDPOINTS))
    // A held byte that cannot be parsed keeps the input side stalled.
    `UCDW_ASSERT_SAME(a_stall_holds, clk, rst_n, item_valid_reg && !fire, !byte_in.ready)

endmodule

`default_nettype wire

/* sv/ucdw_out_queue.sv */
// ----------------------------------------------------------------------------
// USB configuration descriptor walker result queue
// Two-entry register queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ucdw_out_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ucdw_pkg::push_t        push,
    output ucdw_pkg::queue_status_t     q_status,
    ucdw_rec_if.source                  rec_out
);
    import ucdw_pkg::*;

    rec_t       entry_reg [QUEUE_DEPTH];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    rec_t       head;

    assign head = entry_reg[rd_ptr_reg];
    assign pop  = (count_reg != 2'd0) && rec_out.ready;

    assign q_status.free = 2'(QUEUE_DEPTH) - count_reg + {1'b0, pop};

    assign rec_out.valid            = (count_reg != 2'd0);
    assign rec_out.record_kind      = head.kind;
    assign rec_out.endpoint_address = head.endpoint_address;
    assign rec_out.transfer_type    = head.transfer_type;
    assign rec_out.max_packet_size  = head.max_packet_size;
    assign rec_out.poll_interval    = head.poll_interval;
    assign rec_out.endpoint_count   = head.endpoint_count;
    assign rec_out.last_of_run      = head.last_of_run;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push.cnt[0];
        count_next  = count_reg + push.cnt - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[!wr_ptr_reg] <= push.rec1;
        end
    end

endmodule

`default_nettype wire

/* sv/usb_config_descriptor_walker_core.sv */
// ----------------------------------------------------------------------------
// USB configuration descriptor walker
// Walks a configuration descriptor set byte by byte and reports the
// endpoints of the selected interface.
// ----------------------------------------------------------------------------
// The block takes one descriptor byte per word on byte_in and may accept a
// new byte in every cycle while the result queue has room for the results of
// the held byte. An accepted byte is held in an input register and parsed
// once the queue can take all of its results; they land in the two-entry
// result queue, and the first of them appears on rec_out in the cycle after
// it is written. The result queue drains one word per cycle while rec_out is
// ready, which sets the sustained rate: one byte per cycle, except that a
// final byte which also completes an endpoint descriptor yields two results.
// Write the target interface number (0xff matches the first interface found)
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_config_descriptor_walker_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data,
    ucdw_byte_if.sink       byte_in,
    ucdw_rec_if.source      rec_out
);
    import ucdw_pkg::*;

    // Results of each parsed byte travel to the queue, and the queue reports
    // how many entries it can take in the same cycle (counting a pop).
    push_t         push;
    queue_status_t q_status;

    // Parser: input register, walk state and the target register.
    ucdw_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .byte_in        (byte_in),
        .q_status       (q_status),
        .push           (push)
    );

    // Result queue: separates the parser from a stalled consumer.
    ucdw_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_status (q_status),
        .rec_out  (rec_out)
    );

endmodule

`default_nettype wire
